### hdl/nrc_pkg.sv
// Shared constants, types and state codes for the nonce replay cache.
`timescale 1ns / 1ps

package nrc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TIME_W        = 63;
    localparam int CFG_W         = 41;
    localparam int CFG_ADDR_W    = 2;
    localparam int SUM_W         = TIME_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TIME_SKEW = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPIRY_PERIOD = CFG_ADDR_W'(1);

    localparam logic [CFG_W-1:0] MAX_TIME_SKEW_RESET = 41'd300000000;
    localparam logic [CFG_W-1:0] EXPIRY_PERIOD_RESET = 41'd3600000000;

    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_VALIDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DECIDE,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic [TIME_W-1:0] last_use;
        logic [TIME_W-1:0] nonce_time;
    } slot_word_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_word_t       wr_data;
    } ram_req_t;

    typedef struct packed {
        logic              accepted;
        logic              stored;
        logic [TIME_W-1:0] nonce_out;
    } result_t;

endpackage

### hdl/nrc_slot_ram.sv
// Slot memory holding nonce time and last-use time, with a registered read.
`timescale 1ns / 1ps

module nrc_slot_ram (
    input  logic              clk,
    input  nrc_pkg::ram_req_t req,
    output nrc_pkg::slot_word_t rd_data
);
    import nrc_pkg::*;

    slot_word_t mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

### hdl/nrc_ctrl.sv
// Sweep sequencer: expiry, match search, free-slot search and table update.
`timescale 1ns / 1ps

module nrc_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_cmd,
    input  logic [nrc_pkg::TIME_W-1:0]  in_nonce,
    input  logic [nrc_pkg::TIME_W-1:0]  in_server_time,
    input  logic [nrc_pkg::TIME_W-1:0]  in_steady_time,
    input  logic [nrc_pkg::CFG_W-1:0]   max_time_skew,
    input  logic [nrc_pkg::CFG_W-1:0]   expiry_period,
    output nrc_pkg::ram_req_t           ram_req,
    input  nrc_pkg::slot_word_t         ram_rd_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output nrc_pkg::result_t            res
);
    import nrc_pkg::*;

    ctrl_state_t                state_reg, state_next;
    logic [IDX_W-1:0]           rd_addr_reg, rd_addr_next;
    logic                       chk_reg, chk_next;
    logic [IDX_W-1:0]           chk_idx_reg, chk_idx_next;
    logic                       cmd_reg, cmd_next;
    logic [TIME_W-1:0]          nonce_reg, nonce_next;
    logic [TIME_W-1:0]          srv_reg, srv_next;
    logic [TIME_W-1:0]          steady_reg, steady_next;
    logic [TABLE_ENTRIES-1:0]   valid_reg, valid_next;
    logic                       match_found_reg, match_found_next;
    logic [IDX_W-1:0]           match_idx_reg, match_idx_next;
    logic                       free_found_reg, free_found_next;
    logic [IDX_W-1:0]           free_idx_reg, free_idx_next;
    result_t                    res_reg, res_next;

    logic [TIME_W-1:0] key;
    logic [SUM_W-1:0]  expire_sum;
    logic              entry_valid;
    logic              entry_expired;
    logic              entry_live;
    logic [SUM_W-1:0]  win_low_sum;
    logic [SUM_W-1:0]  win_high_sum;
    logic              in_window;
    logic              do_insert;
    logic              do_write;

    // Validate looks up the presented nonce, generate looks up server time.
    assign key = (cmd_reg == CMD_VALIDATE) ? nonce_reg : srv_reg;

    assign expire_sum    = {1'b0, ram_rd_data.last_use} + SUM_W'(expiry_period);
    assign entry_valid   = valid_reg[chk_idx_reg];
    assign entry_expired = (cmd_reg == CMD_VALIDATE) && entry_valid &&
                           (expire_sum < {1'b0, steady_reg});
    assign entry_live    = entry_valid && !entry_expired;

    // Window bounds are formed one bit wider so that neither side can wrap.
    assign win_low_sum  = {1'b0, nonce_reg} + SUM_W'(max_time_skew);
    assign win_high_sum = {1'b0, srv_reg} + SUM_W'(max_time_skew);
    assign in_window    = (win_low_sum > {1'b0, srv_reg}) &&
                          ({1'b0, nonce_reg} < win_high_sum);

    assign do_insert = !match_found_reg && free_found_reg &&
                       ((cmd_reg == CMD_GENERATE) || in_window);
    assign do_write  = (match_found_reg && (cmd_reg == CMD_VALIDATE)) || do_insert;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chk_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chk_reg   <= chk_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg     <= rd_addr_next;
        chk_idx_reg     <= chk_idx_next;
        cmd_reg         <= cmd_next;
        nonce_reg       <= nonce_next;
        srv_reg         <= srv_next;
        steady_reg      <= steady_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        res_reg         <= res_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        rd_addr_next     = rd_addr_reg;
        chk_next         = 1'b0;
        chk_idx_next     = chk_idx_reg;
        cmd_next         = cmd_reg;
        nonce_next       = nonce_reg;
        srv_next         = srv_reg;
        steady_next      = steady_reg;
        valid_next       = valid_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        res_next         = res_reg;

        ram_req         = '0;
        ram_req.wr_addr = match_found_reg ? match_idx_reg : free_idx_reg;
        ram_req.wr_data = '{last_use: steady_reg, nonce_time: key};

        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_RESULT);

        // Entry read in the previous cycle arrives now.
        if (chk_reg)
        begin
            if (entry_expired)
            begin
                valid_next[chk_idx_reg] = 1'b0;
            end
            if (entry_live && !match_found_reg &&
                (ram_rd_data.nonce_time == key))
            begin
                match_found_next = 1'b1;
                match_idx_next   = chk_idx_reg;
            end
            if (!entry_live && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = chk_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next         = in_cmd;
                    nonce_next       = in_nonce;
                    srv_next         = in_server_time;
                    steady_next      = in_steady_time;
                    rd_addr_next     = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    state_next       = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = rd_addr_reg;
                chk_next        = 1'b1;
                chk_idx_next    = rd_addr_reg;
                rd_addr_next    = rd_addr_reg + 1'b1;
                if (rd_addr_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                ram_req.wr_en = do_write;
                if (do_write)
                begin
                    valid_next[ram_req.wr_addr] = 1'b1;
                end
                res_next.accepted  = (cmd_reg == CMD_GENERATE) || match_found_reg ||
                                     in_window;
                res_next.stored    = match_found_reg || do_insert;
                res_next.nonce_out = key;
                state_next         = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

### hdl/nonce_replay_cache_core.sv
// Top level of the nonce replay cache: channels, configuration and output register.
`timescale 1ns / 1ps

// Nonce replay cache.
// Requests arrive on the s_ channel: s_tuser carries the command (generate or
// validate), s_tdata the presented nonce, server time and monotonic time.
// Each request yields exactly one result on the m_ channel: nonce_out in
// m_tdata, accepted and stored flags in m_tuser.
// Every request reads all table slots once from the slot memory, one slot per
// cycle, checking expiry (validate only), match and the lowest free slot, then
// writes back at most one slot. The slots are read one after another through
// the single read port of the slot memory. One request is worked on at a time;
// the next one is taken in the cycle after the result has moved into the
// output register, so no new request is taken before the last one is through.
// If the receiver stalls, the result waits in the output register and the
// block stalls after finishing at most one more request.
// Reset clears all slot valid bits and loads the configuration defaults; the
// memory contents need no clearing. Configuration writes are always ready and
// should only be issued while no request is outstanding.
module nonce_replay_cache_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [191:0]                      s_tdata,   // nonce_value, server_time, steady_time, pad
    input  logic [0:0]                        s_tuser,   // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // nonce_out, pad
    output logic [1:0]                        m_tuser,   // accepted, stored
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nrc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [nrc_pkg::CFG_W-1:0]         cfg_data
);
    import nrc_pkg::*;

    logic [CFG_W-1:0] max_time_skew_reg;
    logic [CFG_W-1:0] expiry_period_reg;
    logic             m_tvalid_reg;
    result_t          out_reg;

    ram_req_t         ram_req;
    slot_word_t       ram_rd_data;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_time_skew_reg <= MAX_TIME_SKEW_RESET;
            expiry_period_reg <= EXPIRY_PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_MAX_TIME_SKEW: max_time_skew_reg <= cfg_data;
                CFG_EXPIRY_PERIOD: expiry_period_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    nrc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_cmd         (s_tuser[0]),
        .in_nonce       (s_tdata[TIME_W-1:0]),
        .in_server_time (s_tdata[2*TIME_W-1:TIME_W]),
        .in_steady_time (s_tdata[3*TIME_W-1:2*TIME_W]),
        .max_time_skew  (max_time_skew_reg),
        .expiry_period  (expiry_period_reg),
        .ram_req        (ram_req),
        .ram_rd_data    (ram_rd_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    nrc_slot_ram u_slot_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    // Output register: loads whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg.nonce_out};
    assign m_tuser  = {out_reg.stored, out_reg.accepted};

endmodule
